@@ rtl/pup_pkg.sv @@
// ----------------------------------------------------------------------------
// pup_pkg
// Shared types for the packed sample unpacker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pup_pkg;

  // Control that travels with the word at the head of the queue.
  typedef struct packed {
    logic valid;
    logic sop;
  } pup_head_t;

endpackage : pup_pkg

`default_nettype wire

@@ rtl/pup_front.sv @@
// ----------------------------------------------------------------------------
// pup_front
// Input side: accepts payload words and holds them in a two-entry queue
// until the unpacking engine takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pup_front #(
  parameter int WORD_BITS = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [WORD_BITS-1:0]   in_payload_word,
  input  wire                    in_start_of_heap,
  output pup_pkg::pup_head_t     head,
  output logic [WORD_BITS-1:0]   head_word,
  input  wire                    head_pop
);
  import pup_pkg::*;

  localparam int DEPTH = 2;

  logic [WORD_BITS-1:0] word_q_r [DEPTH];
  logic                 sop_q_r  [DEPTH];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           count_r,  count_nxt;
  logic                 push;
  logic                 pop;

  assign in_ready = (count_r != 2'(DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = head_pop && (count_r != 2'd0);

  assign head.valid = (count_r != 2'd0);
  assign head.sop   = sop_q_r[rd_ptr_r];
  assign head_word  = word_q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      word_q_r[wr_ptr_r] <= in_payload_word;
      sop_q_r[wr_ptr_r]  <= in_start_of_heap;
    end
  end

endmodule : pup_front

`default_nettype wire

@@ rtl/pup_back.sv @@
// ----------------------------------------------------------------------------
// pup_back
// Unpacking engine: joins the leftover bits with the current word and emits
// one sample per cycle into the output register unless out_ready stalls it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pup_back #(
  parameter int SAMPLE_BITS = 10,
  parameter int WORD_BITS   = 32
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire pup_pkg::pup_head_t       head,
  input  wire  [WORD_BITS-1:0]          head_word,
  output logic                          head_pop,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last_of_word
);
  import pup_pkg::*;

  localparam int LO_W  = SAMPLE_BITS - 1;
  localparam int BUF_W = LO_W + WORD_BITS;
  localparam int CNT_W = $clog2(BUF_W + 1);

  // Bit buffer is {leftover, word}, right aligned; cnt_r counts the bits
  // still to be emitted, counted from the bottom of the word upward.
  logic [WORD_BITS-1:0]   word_r;
  logic [LO_W-1:0]        lo_r;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   active_r, active_nxt;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   last_r;

  logic [BUF_W-1:0]       buf_w;
  logic [BUF_W-1:0]       shifted;
  logic [CNT_W-1:0]       cnt_after;
  logic [CNT_W-1:0]       cnt_base;
  logic                   advance;
  logic                   is_last;
  logic                   load;

  assign buf_w     = {lo_r, word_r};
  assign cnt_after = cnt_r - CNT_W'(SAMPLE_BITS);
  assign shifted   = buf_w >> cnt_after;
  assign is_last   = (cnt_after < CNT_W'(SAMPLE_BITS));
  assign advance   = active_r && (!out_valid_r || out_ready);
  assign load      = head.valid && (!active_r || (advance && is_last));
  assign head_pop  = load;

  assign out_valid        = out_valid_r;
  assign out_sample       = sample_r;
  assign out_last_of_word = last_r;

  always_comb begin
    cnt_base   = advance ? cnt_after : cnt_r;
    cnt_nxt    = cnt_base;
    active_nxt = active_r;
    if (advance && is_last) begin
      active_nxt = 1'b0;
    end
    if (load) begin
      // A start of heap drops whatever bits are still buffered.
      cnt_nxt    = (head.sop ? CNT_W'(0) : cnt_base) + CNT_W'(WORD_BITS);
      active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= head_word;
      // Leftover bits always come from the tail of the previous word.
      lo_r   <= word_r[LO_W-1:0];
    end
    if (advance) begin
      sample_r <= shifted[SAMPLE_BITS-1:0];
      last_r   <= is_last;
    end
  end

endmodule : pup_back

`default_nettype wire

@@ rtl/packed_10bit_sample_unpacker.sv @@
// ----------------------------------------------------------------------------
// packed_10bit_sample_unpacker
// Splits a stream of packed big-endian payload words into signed samples.
// ----------------------------------------------------------------------------
// Each accepted word is appended, most significant bit first, behind the bits
// left over from earlier words, and every complete SAMPLE_BITS group is
// emitted oldest first as a signed sample; the final sample of a word is
// flagged with out_last_of_word. A word yields three or four samples at the
// default sizes; the engine emits one sample per cycle into the output
// register unless out_ready stalls it. A two-entry queue in front of the
// engine keeps accepting words until it is full while samples are emitted.
// A word with in_start_of_heap set discards any buffered leftover bits first.
`timescale 1ns / 1ps
`default_nettype none

module packed_10bit_sample_unpacker #(
  parameter int SAMPLE_BITS = 10,
  parameter int WORD_BITS   = 32
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [WORD_BITS-1:0]          in_payload_word,
  input  wire                           in_start_of_heap,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last_of_word
);
  import pup_pkg::*;

  pup_head_t            head;
  logic [WORD_BITS-1:0] head_word;
  logic                 head_pop;

  pup_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_payload_word (in_payload_word),
    .in_start_of_heap(in_start_of_heap),
    .head            (head),
    .head_word       (head_word),
    .head_pop        (head_pop)
  );

  pup_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .WORD_BITS  (WORD_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_word       (head_word),
    .head_pop        (head_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_last_of_word(out_last_of_word)
  );

endmodule : packed_10bit_sample_unpacker

`default_nettype wire
